// ----- hw/rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, operation and status codes, types and index helpers for the
// bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [1:0] t_op;
    localparam t_op OP_PUSH_FRONT = 2'd0;
    localparam t_op OP_PUSH_BACK  = 2'd1;
    localparam t_op OP_POP_FRONT  = 2'd2;
    localparam t_op OP_POP_BACK   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_POP_EMPTY  = 2'd1;
    localparam t_status ST_PUSH_FULL  = 2'd2;

    typedef logic [AW-1:0]     t_addr;
    typedef logic [CW-1:0]     t_count;
    typedef logic [DATA_W-1:0] t_data;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        logic  re;
        t_addr raddr_front;
        t_addr raddr_back;
    } t_mem_req;

    typedef struct packed {
        t_status status;
        t_count  count;
    } t_meta;

    localparam t_addr  LAST_ADDR = AW'(DEPTH - 1);
    localparam t_count FULL_CNT  = CW'(DEPTH);

    // circular add, both operands below DEPTH
    function automatic t_addr bdq_wrap(input t_addr base, input t_addr off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic t_addr bdq_dec(input t_addr base);
        return (base == '0) ? LAST_ADDR : base - AW'(1);
    endfunction

endpackage

// ----- hw/rtl/bdq_if.sv -----
// ----------------------------------------------------------------------------
// bdq_if
// Request and response channels of the queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdq_in_if import bdq_pkg::*; ();
    logic               valid;
    logic               ready;
    t_op                operation;
    logic signed [31:0] value;

    modport source (output valid, operation, value, input ready);
    modport sink   (input valid, operation, value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    t_count             count;
    logic               is_empty;

    modport source (output valid, status, front_value, back_value, count, is_empty,
                    input ready);
    modport sink   (input valid, status, front_value, back_value, count, is_empty,
                    output ready);
endinterface

// ----- hw/rtl/bounded_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit values in a circular store.
// ----------------------------------------------------------------------------
// pipeline: an accepted request loads the pending register and the store read
//   registers; the response register loads from them once it is free or taken
// throughput: one request per cycle while results are taken; a held response
//   lets one more request in, then blocks new requests until it is taken
// reset: synchronous, active low; clears front pointer, count and handshake
//   state; store contents stay undefined, no clearing pass is run
module bounded_deque import bdq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bdq_in_if.sink    i_req,
    bdq_out_if.source o_rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic     r_state, n_state;
    logic     r_out_valid;
    t_meta    r_pend;
    t_mem_req mem;
    t_meta    meta;
    t_data    rdata_front;
    t_data    rdata_back;
    logic     out_load;
    logic     accept;

    t_status            r_status;
    logic signed [31:0] r_front;
    logic signed [31:0] r_back;
    t_count             r_count;

    assign out_load    = (r_state == S_READ) && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE) || out_load;
    assign accept      = i_req.valid && i_req.ready;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_req.operation),
        .i_value     (t_data'(i_req.value)),
        .o_mem       (mem),
        .o_meta      (meta)
    );

    bdq_ram #(.W(DATA_W), .N(DEPTH), .AW(AW)) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem.we),
        .i_waddr   (mem.waddr),
        .i_wdata   (mem.wdata),
        .i_re      (mem.re),
        .i_raddr_a (mem.raddr_front),
        .i_raddr_b (mem.raddr_back),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_back)
    );

    always_comb begin
        priority if (accept) begin
            n_state = S_READ;
        end else if (out_load) begin
            n_state = S_IDLE;
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= meta;
        end
        if (out_load) begin
            r_status <= r_pend.status;
            r_count  <= r_pend.count;
            r_front  <= (r_pend.count == '0) ? '0 : $signed(rdata_front);
            r_back   <= (r_pend.count == '0) ? '0 : $signed(rdata_back);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.front_value = r_front;
    assign o_rsp.back_value  = r_back;
    assign o_rsp.count       = r_count;
    assign o_rsp.is_empty    = (r_count == '0);

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.is_empty |-> o_rsp.front_value == 0 && o_rsp.back_value == 0)
        else $error("empty result with nonzero ends");

    a_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_READ)
        else $error("accepted request not pending");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

// ----- hw/rtl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Element store: one write port, two registered read ports, write-first
// on an address match.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int W = 32,
    parameter int N = 16,
    parameter int AW = (N > 1) ? $clog2(N) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_rdata_a,
    output logic [W-1:0]  o_rdata_b
);

    logic [W-1:0] r_mem [N];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // a write in the same cycle is forwarded to the read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= (i_we && i_waddr == i_raddr_a) ? i_wdata : r_mem[i_raddr_a];
            o_rdata_b <= (i_we && i_waddr == i_raddr_b) ? i_wdata : r_mem[i_raddr_b];
        end
    end

endmodule

// ----- hw/rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Front pointer and element count; turns one request into a store write,
// the read addresses of the new ends and the result status.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_op      i_operation,
    input  t_data    i_value,
    output t_mem_req o_mem,
    output t_meta    o_meta
);

    t_addr   r_fp,  n_fp;
    t_count  r_cnt, n_cnt;
    t_status status;
    logic    we;
    t_addr   waddr;
    t_count  cnt_m1;

    always_comb begin
        n_fp   = r_fp;
        n_cnt  = r_cnt;
        status = ST_OK;
        we     = 1'b0;
        waddr  = r_fp;
        unique case (i_operation)
            OP_PUSH_FRONT: begin
                if (r_cnt == FULL_CNT) begin
                    status = ST_PUSH_FULL;
                end else begin
                    n_fp  = bdq_dec(r_fp);
                    waddr = n_fp;
                    we    = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (r_cnt == FULL_CNT) begin
                    status = ST_PUSH_FULL;
                end else begin
                    waddr = bdq_wrap(r_fp, r_cnt[AW-1:0]);
                    we    = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (r_cnt == '0) begin
                    status = ST_POP_EMPTY;
                end else begin
                    n_fp  = bdq_wrap(r_fp, AW'(1));
                    n_cnt = r_cnt - CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (r_cnt == '0) begin
                    status = ST_POP_EMPTY;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            default: ;
        endcase
    end

    assign cnt_m1 = n_cnt - CW'(1);

    always_comb begin
        o_mem.we          = i_accept && we;
        o_mem.waddr       = waddr;
        o_mem.wdata       = i_value;
        o_mem.re          = i_accept;
        o_mem.raddr_front = n_fp;
        // back address only matters when the queue is not empty
        o_mem.raddr_back  = bdq_wrap(n_fp, cnt_m1[AW-1:0]);
        o_meta.status     = status;
        o_meta.count      = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp  <= '0;
            r_cnt <= '0;
        end else if (i_accept) begin
            r_fp  <= n_fp;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("element count above depth");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_cnt == FULL_CNT &&
        (i_operation == OP_PUSH_FRONT || i_operation == OP_PUSH_BACK)
        |=> $stable(r_cnt) && $stable(r_fp))
        else $error("push on full queue changed state");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_cnt == '0 &&
        (i_operation == OP_POP_FRONT || i_operation == OP_POP_BACK)
        |=> $stable(r_cnt) && $stable(r_fp))
        else $error("pop on empty queue changed state");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> r_cnt != FULL_CNT)
        else $error("store written while full");

endmodule

// ----- dv/deque_checker.sv -----
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request and response channels of the bounded deque, keeps a
// shadow copy of the queue contents, predicts each response and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module deque_checker import bdq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bdq_in_if    i_req,
    bdq_out_if   i_rsp,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_full_rejects,
    output int   o_empty_rejects
);

    typedef struct packed {
        t_status status;
        t_data   front_value;
        t_data   back_value;
        t_count  count;
        logic    is_empty;
    } t_deque_view;

    localparam int REPORT_LIMIT = 10;

    // shadow of the circular store
    t_data slots [DEPTH];
    int    head = 0;
    int    fill = 0;

    t_deque_view expected_views [$];

    int mismatches    = 0;
    int pending_q     = 0;
    int full_rejects  = 0;
    int empty_rejects = 0;

    assign o_mismatches    = mismatches;
    assign o_pending       = pending_q;
    assign o_full_rejects  = full_rejects;
    assign o_empty_rejects = empty_rejects;

    task automatic predict_request(input t_op op, input t_data val,
                                   output t_deque_view view);
        view        = '0;
        view.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill == DEPTH) begin
                    view.status = ST_PUSH_FULL;
                end else if (op == OP_PUSH_FRONT) begin
                    head        = (head + DEPTH - 1) % DEPTH;
                    slots[head] = val;
                    fill++;
                end else begin
                    slots[(head + fill) % DEPTH] = val;
                    fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (fill == 0) begin
                    view.status = ST_POP_EMPTY;
                end else if (op == OP_POP_FRONT) begin
                    head = (head + 1) % DEPTH;
                    fill--;
                end else begin
                    fill--;
                end
            end
        endcase
        // front and back read as zero once drained, head keeps its place
        if (fill != 0) begin
            view.front_value = slots[head];
            view.back_value  = slots[(head + fill - 1) % DEPTH];
        end
        view.count    = t_count'(fill);
        view.is_empty = (fill == 0);
    endtask

    always @(posedge i_clk) begin
        t_deque_view want;
        t_deque_view got;
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.status      = i_rsp.status;
                got.front_value = i_rsp.front_value;
                got.back_value  = i_rsp.back_value;
                got.count       = i_rsp.count;
                got.is_empty    = i_rsp.is_empty;
                if (expected_views.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch: response with nothing expected:");
                        $display("          actual   st=%0d f=%0d b=%0d n=%0d e=%0b",
                                 got.status, $signed(got.front_value),
                                 $signed(got.back_value), got.count, got.is_empty);
                    end
                end else begin
                    want = expected_views[0];
                    expected_views.delete(0);
                    if (got.status !== want.status ||
                        got.front_value !== want.front_value ||
                        got.back_value !== want.back_value || got.count !== want.count ||
                        got.is_empty !== want.is_empty) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("mismatch: expected st=%0d f=%0d b=%0d n=%0d e=%0b",
                                     want.status, $signed(want.front_value),
                                     $signed(want.back_value), want.count, want.is_empty);
                            $display("          actual   st=%0d f=%0d b=%0d n=%0d e=%0b",
                                     got.status, $signed(got.front_value),
                                     $signed(got.back_value), got.count, got.is_empty);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.operation, i_req.value, want);
                expected_views.insert(expected_views.size(), want);
                if (want.status == ST_PUSH_FULL) begin
                    full_rejects++;
                end
                if (want.status == ST_POP_EMPTY) begin
                    empty_rejects++;
                end
            end
            pending_q <= expected_views.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop requests into the bounded deque under several idle and
// stall patterns; the checker beside the block predicts and compares every
// response, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import bdq_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 300;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               src_valid     = 1'b0;
    t_op                src_operation = OP_PUSH_FRONT;
    logic signed [31:0] src_value     = '0;
    logic               sink_ready    = 1'b0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int idle_cycles    = 0;
    int requests_sent  = 0;
    int op_counts [4]  = '{0, 0, 0, 0};

    int mismatches;
    int pending;
    int full_rejects;
    int empty_rejects;

    bdq_in_if  req_if ();
    bdq_out_if rsp_if ();

    assign req_if.valid     = src_valid;
    assign req_if.operation = src_operation;
    assign req_if.value     = src_value;
    assign rsp_if.ready     = sink_ready;

    bounded_deque dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    deque_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_if),
        .i_rsp           (rsp_if),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_full_rejects  (full_rejects),
        .o_empty_rejects (empty_rejects)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        sink_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog: cycles in which neither channel moves anything
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_request(input t_op op, input logic signed [31:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            src_valid <= 1'b0;
            @(posedge i_clk);
        end
        src_valid     <= 1'b1;
        src_operation <= op;
        src_value     <= val;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        requests_sent++;
        op_counts[op]++;
    endtask

    // hold off new requests until every response is back
    task automatic drain_responses();
        src_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // push_pct steers the fill level toward full or toward empty
    task automatic random_burst(input int n, input int push_pct);
        t_op op;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < push_pct) begin
                op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else begin
                op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            end
            send_request(op, pick_value());
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct);
        int sent;
        int len;
        int bias;
        sent           = 0;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (sent < PHASE_ITEMS) begin
            len = $urandom_range(70, 20);
            case ($urandom_range(2))
                0:       bias = 80;
                1:       bias = 20;
                default: bias = 50;
            endcase
            random_burst(len, bias);
            sent += len;
        end
        drain_responses();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pops on an empty queue
        send_request(OP_POP_FRONT, 32'sh7fff_ffff);
        send_request(OP_POP_BACK, 32'sh8000_0000);
        // extremes at both ends, front push wraps the pointer below zero
        send_request(OP_PUSH_FRONT, 32'sh8000_0000);
        send_request(OP_PUSH_BACK, 32'sh7fff_ffff);
        send_request(OP_PUSH_FRONT, -32'sd1);
        send_request(OP_PUSH_BACK, 32'sh0000_0000);
        send_request(OP_POP_FRONT, -32'sd1);
        send_request(OP_POP_BACK, 32'sh0000_0000);
        // fill to the brim, then pushes on a full queue
        for (int k = 0; k < DEPTH - 2; k++) begin
            send_request((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                         (k % 3 == 0) ? 32'sh5555_5555 : 32'shaaaa_aaaa);
        end
        send_request(OP_PUSH_FRONT, 32'sh1234_5678);
        send_request(OP_PUSH_BACK, -32'sh1234_5678);
        drain_responses();

        run_phase(0, 0);
        run_phase(87, 0);
        run_phase(0, 87);
        run_phase(33, 33);

        src_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("summary: %0d requests (push front %0d, push back %0d, pop front %0d, pop back %0d)",
                 requests_sent, op_counts[OP_PUSH_FRONT], op_counts[OP_PUSH_BACK],
                 op_counts[OP_POP_FRONT], op_counts[OP_POP_BACK]);
        $display("summary: %0d pushes refused on full, %0d pops refused on empty, %0d mismatches",
                 full_rejects, empty_rejects, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_if.sv
hw/rtl/bdq_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bounded_deque.sv
dv/deque_checker.sv
dv/testbench.sv
